### rtl/core/egw_pkg.sv
// Shared types and constants for the Exp-Golomb bit writer.
package egw_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned LEN_W  = 6;
	localparam int unsigned FILL_W = 5;
	localparam int unsigned CODE_W = 64;
	localparam int unsigned CLEN_W = 7;
	localparam int unsigned ACC_W  = 96;

	localparam logic [2:0] OP_BITS  = 3'd0;
	localparam logic [2:0] OP_UE    = 3'd1;
	localparam logic [2:0] OP_SE    = 3'd2;
	localparam logic [2:0] OP_ALIGN = 3'd3;
	localparam logic [2:0] OP_TRAIL = 3'd4;
	localparam logic [2:0] OP_FLUSH = 3'd5;

	localparam logic [LEN_W-1:0] FULL_WORD_BITS = 6'd32;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [WORD_W-1:0] value;
		logic [LEN_W-1:0]  bit_length;
	} egw_cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [LEN_W-1:0]  word_bits;
		logic              last;
		logic [WORD_W-1:0] total_bits;
		logic              error;
	} egw_res_t;

	// Bit string to append for one field, right-aligned in bits
	typedef struct packed {
		logic [CODE_W-1:0] bits;
		logic [CLEN_W-1:0] len;
		logic              error;
		logic              flush;
		logic              ignore;
	} egw_code_t;

	typedef struct packed {
		logic [1:0] count;
		egw_res_t   first;
		egw_res_t   second;
	} egw_push_t;

endpackage

### rtl/core/exp_golomb_bit_writer.sv
// Exp-Golomb bit writer top level: command register, coder, packer, result queue.
//
// Commands enter on cmd (valid/ready) and carry one header field each: a
// fixed-length put, an unsigned or signed Exp-Golomb code, byte alignment,
// RBSP trailing bits or a flush. Results leave on res (valid/ready): one
// word of 32 packed bits MSB-first, the final partial word with last and
// the stream length on flush, or an error word for an unencodable value.
// A command is held in the command register, written by the packer into the
// result queue once that has room, and its first word is offered from there.
// Throughput: one command a cycle while the result queue has room; a
// command that fills two words pushes both at once, and the single result
// port hands them out in turn. A four entry result queue absorbs such bursts.
// Reset empties the stream (no pending bits, bit count zero) and the queue.
// When the receiver stalls the queue fills, the command register holds and
// cmd_ready drops until there is room for two more words.
module exp_golomb_bit_writer
	import egw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  egw_cmd_t cmd,
	output logic     res_valid,
	input  logic     res_ready,
	output egw_res_t res
);

	egw_cmd_t          cmd_s1;
	logic              valid_s1;
	logic              room;
	logic              step;
	logic [FILL_W-1:0] fill;
	egw_code_t         code;
	egw_push_t         push;

	assign step      = valid_s1 && room;
	assign cmd_ready = !valid_s1 || step;

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	egw_field_coder u_coder (
		.cmd  (cmd_s1),
		.fill (fill),
		.code (code)
	);

	egw_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.code   (code),
		.fill   (fill),
		.push   (push)
	);

	egw_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

`ifndef ASSERT_OFF
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room) |=> (valid_s1 && $stable(cmd_s1)))
		else $error("stalled command lost");
`endif

endmodule

### rtl/core/egw_field_coder.sv
// Field coder: turns one command into a bit string and its length.
module egw_field_coder
	import egw_pkg::*;
(
	input  egw_cmd_t          cmd,
	input  logic [FILL_W-1:0] fill,
	output egw_code_t         code
);

	logic [WORD_W-1:0] neg_value;
	logic              se_neg;
	logic [WORD_W-1:0] gcode;
	logic [4:0]        msb;
	logic [LEN_W-1:0]  fixed_len;
	logic [CODE_W-1:0] fixed_mask;
	logic [2:0]        off;
	logic [3:0]        left;

	assign neg_value = 32'd0 - cmd.value;
	assign se_neg    = cmd.value[WORD_W-1] || (cmd.value == 32'd0);
	assign off       = fill[2:0];
	assign left      = 4'd8 - {1'b0, off};
	assign fixed_len = (cmd.bit_length > FULL_WORD_BITS) ? FULL_WORD_BITS : cmd.bit_length;
	assign fixed_mask = (64'd1 << fixed_len) - 64'd1;

	// Golomb code word: value + 1 for unsigned, mapped value + 1 for signed
	always_comb begin
		if (cmd.opcode == OP_SE) begin
			gcode = se_neg ? {neg_value[WORD_W-2:0], 1'b1} : {cmd.value[WORD_W-2:0], 1'b0};
		end else begin
			gcode = cmd.value + 32'd1;
		end
	end

	always_comb begin
		msb = 5'd0;
		for (int i = 0; i < WORD_W; i++) begin
			if (gcode[i]) begin
				msb = 5'(i);
			end
		end
	end

	always_comb begin
		code = '0;
		unique case (cmd.opcode)
			OP_BITS: begin
				code.bits = {32'd0, cmd.value} & fixed_mask;
				code.len  = {1'b0, fixed_len};
			end
			OP_UE: begin
				code.error = (cmd.value == 32'hFFFF_FFFF);
				code.bits  = {32'd0, gcode};
				code.len   = {1'b0, msb, 1'b0} + 7'd1;
			end
			OP_SE: begin
				code.error = (cmd.value == 32'h8000_0000);
				code.bits  = {32'd0, gcode};
				code.len   = {1'b0, msb, 1'b0} + 7'd1;
			end
			OP_ALIGN: begin
				if (off != 3'd0) begin
					code.len  = {3'd0, left};
					code.bits = cmd.value[0] ? ((64'd1 << left) - 64'd1) : 64'd0;
				end
			end
			OP_TRAIL: begin
				// stop bit then zeros up to the byte boundary
				code.len  = {3'd0, left};
				code.bits = 64'd1 << (left - 4'd1);
			end
			OP_FLUSH: begin
				code.flush = 1'b1;
			end
			default: begin
				code.ignore = 1'b1;
			end
		endcase
	end

endmodule

### rtl/core/egw_packer.sv
// Packer: holds the partial word and bit count, emits full words.
module egw_packer
	import egw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  egw_code_t         code,
	output logic [FILL_W-1:0] fill,
	output egw_push_t         push
);

	logic [WORD_W-1:0] partial_q;
	logic [FILL_W-1:0] fill_q;
	logic [WORD_W-1:0] total_q;

	logic [ACC_W-1:0]  acc;
	logic [ACC_W-1:0]  acc_hi;
	logic [ACC_W-1:0]  acc_lo;
	logic [CLEN_W-1:0] sum;
	logic [FILL_W-1:0] rest;
	logic [1:0]        nwords;
	logic [WORD_W:0]   total_sum;
	logic [WORD_W-1:0] total_next;
	logic [WORD_W-1:0] partial_next;
	egw_res_t          word_hi;
	egw_res_t          word_lo;
	egw_res_t          flush_res;
	egw_res_t          err_res;

	assign fill = fill_q;

	assign acc    = ({64'd0, partial_q} << code.len) | {32'd0, code.bits};
	assign sum    = {2'd0, fill_q} + code.len;
	assign rest   = sum[FILL_W-1:0];
	assign nwords = sum[CLEN_W-1:FILL_W];
	assign acc_hi = acc >> ({2'd0, rest} + 7'd32);
	assign acc_lo = acc >> rest;
	assign partial_next = acc[WORD_W-1:0] & ((32'd1 << rest) - 32'd1);

	assign total_sum  = {1'b0, total_q} + {26'd0, code.len};
	assign total_next = total_sum[WORD_W] ? 32'hFFFF_FFFF : total_sum[WORD_W-1:0];

	always_comb begin
		word_hi = '0;
		word_hi.word      = acc_hi[WORD_W-1:0];
		word_hi.word_bits = FULL_WORD_BITS;
		word_lo = '0;
		word_lo.word      = acc_lo[WORD_W-1:0];
		word_lo.word_bits = FULL_WORD_BITS;
		flush_res = '0;
		flush_res.word       = partial_q << (6'd32 - {1'b0, fill_q});
		flush_res.word_bits  = {1'b0, fill_q};
		flush_res.last       = 1'b1;
		flush_res.total_bits = total_q;
		err_res = '0;
		err_res.error = 1'b1;
	end

	always_comb begin
		push = '0;
		if (step) begin
			priority if (code.ignore) begin
				push.count = 2'd0;
			end else if (code.error) begin
				push.count = 2'd1;
				push.first = err_res;
			end else if (code.flush) begin
				push.count = 2'd1;
				push.first = flush_res;
			end else if (nwords == 2'd2) begin
				push.count  = 2'd2;
				push.first  = word_hi;
				push.second = word_lo;
			end else begin
				push.count = nwords;
				push.first = word_lo;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			fill_q    <= '0;
			total_q   <= '0;
		end else if (step && !code.ignore && !code.error) begin
			if (code.flush) begin
				partial_q <= '0;
				fill_q    <= '0;
				total_q   <= '0;
			end else begin
				partial_q <= partial_next;
				fill_q    <= rest;
				total_q   <= total_next;
			end
		end
	end

`ifndef ASSERT_OFF
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && code.flush && !code.ignore && !code.error) |=> (fill_q == '0 && total_q == '0))
		else $error("flush did not start a new stream");
	a_two_full: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd2) |->
		(push.first.word_bits == FULL_WORD_BITS && push.second.word_bits == FULL_WORD_BITS))
		else $error("double push with a partial word");
`endif

endmodule

### rtl/core/egw_res_fifo.sv
// Result queue: four entries, up to two pushes and one pop a cycle.
module egw_res_fifo
	import egw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  egw_push_t push,
	output logic      room,
	output logic      res_valid,
	input  logic      res_ready,
	output egw_res_t  res
);

	egw_res_t   mem [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;

	assign room      = (count_q <= 3'd2);
	assign res_valid = (count_q != 3'd0);
	assign res       = mem[rd_ptr_q];
	assign pop       = res_valid && res_ready;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem[wr_ptr_q + 2'd1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.count;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, push.count} - {2'd0, pop};
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0) |-> (count_q <= 3'd2))
		else $error("push without room for two words");
`endif

endmodule

### dv/exp_golomb_bit_writer_tb.sv
// Self-checking testbench for the Exp-Golomb bit writer: directed fields, back-pressure, random streams.
`timescale 1ns / 100ps

module exp_golomb_bit_writer_tb;
	import egw_pkg::*;

	// Opcodes the block must ignore
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	localparam int IDLE_PCT    = 27;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 16;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_ready;
	egw_cmd_t cmd       = '0;
	logic     res_valid;
	logic     res_ready = 1'b0;
	egw_res_t res;

	// Predicted stream state
	logic [31:0] pend_word;
	int unsigned pend_fill;
	logic [31:0] stream_len;
	int          words_this_cmd;
	egw_res_t    expected_words[$];

	int mismatches  = 0;
	int idle_cycles = 0;
	bit no_idle     = 1'b0;
	int hold_seq    = 0;

	exp_golomb_bit_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void expect_word(logic [31:0] w, logic [5:0] nbits, logic lst,
			logic [31:0] tot, logic err);
		egw_res_t r;
		if (words_this_cmd >= 2)
			return;
		r.word       = w;
		r.word_bits  = nbits;
		r.last       = lst;
		r.total_bits = tot;
		r.error      = err;
		expected_words.push_back(r);
		words_this_cmd++;
	endfunction

	function automatic void append_bits(logic [31:0] v, int unsigned n);
		logic [63:0] acc;
		int unsigned sum;
		int unsigned rest;
		if (n == 0)
			return;
		if (n > 32)
			n = 32;
		acc = ({32'd0, pend_word} << n) | ({32'd0, v} & ((64'd1 << n) - 64'd1));
		sum = pend_fill + n;
		if (sum >= 32) begin
			rest = sum - 32;
			expect_word(32'(acc >> rest), FULL_WORD_BITS, 1'b0, 32'd0, 1'b0);
			pend_fill = rest;
			pend_word = 32'(acc & ((64'd1 << rest) - 64'd1));
		end else begin
			pend_fill = sum;
			pend_word = acc[31:0];
		end
		if (stream_len > 32'hFFFF_FFFF - 32'(n))
			stream_len = 32'hFFFF_FFFF;
		else
			stream_len = stream_len + 32'(n);
	endfunction

	function automatic void append_ue(logic [31:0] v);
		logic [31:0] code;
		int unsigned len;
		code = v + 32'd1;
		len  = 0;
		for (int i = 0; i < 32; i++)
			if (code[i])
				len = i + 1;
		append_bits(32'd0, len - 1);
		append_bits(code, len);
	endfunction

	function automatic void pad_to_byte(logic fill_bit);
		int unsigned off;
		int unsigned left;
		off = pend_fill & 7;
		if (off == 0)
			return;
		left = 8 - off;
		append_bits(fill_bit ? (32'd1 << left) - 32'd1 : 32'd0, left);
	endfunction

	function automatic void predict_cmd(egw_cmd_t c);
		words_this_cmd = 0;
		case (c.opcode)
			OP_BITS: begin
				append_bits(c.value, c.bit_length);
			end
			OP_UE: begin
				if (c.value == 32'hFFFF_FFFF)
					expect_word(32'd0, 6'd0, 1'b0, 32'd0, 1'b1);
				else
					append_ue(c.value);
			end
			OP_SE: begin
				if (c.value == 32'h8000_0000)
					expect_word(32'd0, 6'd0, 1'b0, 32'd0, 1'b1);
				else if (c.value == 32'd0 || c.value[31])
					append_ue((32'd0 - c.value) << 1);
				else
					append_ue((c.value << 1) - 32'd1);
			end
			OP_ALIGN: begin
				pad_to_byte(c.value[0]);
			end
			OP_TRAIL: begin
				append_bits(32'd1, 1);
				pad_to_byte(1'b0);
			end
			OP_FLUSH: begin
				expect_word((pend_fill != 0) ? pend_word << (32 - pend_fill) : 32'd0,
					6'(pend_fill), 1'b1, stream_len, 1'b0);
				pend_word  = '0;
				pend_fill  = 0;
				stream_len = '0;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			pend_word  = '0;
			pend_fill  = 0;
			stream_len = '0;
		end else if (cmd_valid && cmd_ready) begin
			predict_cmd(cmd);
		end
	end

	always @(posedge clk) begin : check_words
		egw_res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_words.size() == 0) begin
				$error("word %h arrived with nothing expected", res.word);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				check_field("word", want.word, res.word);
				check_field("word_bits", 32'(want.word_bits), 32'(res.word_bits));
				check_field("last", 32'(want.last), 32'(res.last));
				check_field("total_bits", want.total_bits, res.total_bits);
				check_field("error", 32'(want.error), 32'(res.error));
			end
		end
	end

	// Receiver: random stalls, plus a long hold whenever the test asks for one
	always @(negedge clk) begin : receiver
		int hold_seen;
		int hold_left;
		if (!arst_n) begin
			hold_seen = hold_seq;
			hold_left = 0;
			res_ready <= 1'b0;
		end else begin
			if (hold_seen != hold_seq) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (no_idle) begin
				res_ready <= 1'b1;
			end else begin
				res_ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Offer one command and hold it until it is taken
	task automatic send_cmd(input logic [2:0] op, input logic [31:0] val, input logic [5:0] len);
		@(negedge clk);
		if (!no_idle)
			while ($urandom_range(99) < IDLE_PCT) begin
				cmd_valid <= 1'b0;
				@(negedge clk);
			end
		cmd_valid <= 1'b1;
		cmd       <= '{opcode: op, value: val, bit_length: len};
		do
			@(posedge clk);
		while (!cmd_ready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_golomb_value(bit is_signed);
		logic [31:0] v;
		int r;
		r = $urandom_range(99);
		if (r < 50) begin
			v = $urandom_range(31);
			if (is_signed && $urandom_range(1))
				v = -v;
		end else if (r < 95) begin
			v = $urandom >> $urandom_range(31);
			if (is_signed && $urandom_range(1))
				v = -v;
		end else if (is_signed) begin
			case ($urandom_range(2))
				0: v = 32'h8000_0000;
				1: v = 32'h7FFF_FFFF;
				default: v = 32'h8000_0001;
			endcase
		end else begin
			v = $urandom_range(1) ? 32'hFFFF_FFFF : 32'hFFFF_FFFE;
		end
		return v;
	endfunction

	task automatic test_flush();
		send_cmd(OP_FLUSH, $urandom, 6'($urandom_range(63)));
		send_cmd(OP_BITS, 32'h0000_0005, 6'd3);
		send_cmd(OP_FLUSH, 32'd0, 6'd0);
	endtask

	task automatic test_fixed_puts();
		send_cmd(OP_BITS, 32'hFFFF_FFFF, 6'd0);
		send_cmd(OP_BITS, 32'hFFFF_FFFF, 6'd1);
		send_cmd(OP_BITS, 32'hFFFF_FFFF, 6'd5);
		send_cmd(OP_BITS, 32'hA5A5_A5A5, 6'd32);
		send_cmd(OP_BITS, 32'h1234_5678, 6'd33);
		send_cmd(OP_BITS, 32'hFFFF_FFFF, 6'd63);
	endtask

	task automatic test_golomb_codes();
		send_cmd(OP_UE, 32'd0, 6'd0);
		send_cmd(OP_UE, 32'd1, 6'd0);
		send_cmd(OP_UE, 32'hFFFF_FFFE, 6'd0);
		send_cmd(OP_UE, 32'hFFFF_FFFF, 6'd0);
		send_cmd(OP_SE, 32'd0, 6'd0);
		send_cmd(OP_SE, 32'd1, 6'd0);
		send_cmd(OP_SE, 32'hFFFF_FFFF, 6'd0);
		send_cmd(OP_SE, 32'h7FFF_FFFF, 6'd0);
		send_cmd(OP_SE, 32'h8000_0001, 6'd0);
		send_cmd(OP_SE, 32'h8000_0000, 6'd0);
	endtask

	task automatic test_align_and_trailing();
		send_cmd(OP_FLUSH, 32'd0, 6'd0);
		// aligned already: nothing written
		send_cmd(OP_ALIGN, 32'd1, 6'd0);
		send_cmd(OP_BITS, 32'd5, 6'd3);
		send_cmd(OP_ALIGN, 32'd1, 6'd0);
		send_cmd(OP_BITS, 32'd2, 6'd2);
		// only bit 0 selects the fill
		send_cmd(OP_ALIGN, 32'hFFFF_FFFE, 6'd0);
		send_cmd(OP_BITS, 32'd1, 6'd1);
		send_cmd(OP_TRAIL, $urandom, 6'($urandom_range(63)));
		send_cmd(OP_TRAIL, 32'd0, 6'd0);
	endtask

	task automatic test_spare_opcodes();
		send_cmd(OP_SPARE6, 32'hFFFF_FFFF, 6'd63);
		send_cmd(OP_SPARE7, 32'hFFFF_FFFF, 6'd63);
		send_cmd(OP_FLUSH, 32'd0, 6'd0);
	endtask

	task automatic test_backpressure();
		no_idle = 1'b1;
		hold_seq++;
		repeat (40)
			send_cmd(OP_BITS, $urandom, 6'd32);
		no_idle = 1'b0;
	endtask

	task automatic test_random_stream(input int n);
		int          sent;
		int          r;
		logic [2:0]  op;
		logic [31:0] val;
		logic [5:0]  len;
		sent = 0;
		while (sent < n) begin
			r   = $urandom_range(99);
			val = $urandom;
			len = 6'($urandom_range(63));
			if (r < 30) begin
				op  = OP_BITS;
				len = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 33)) :
					6'($urandom_range(32));
			end else if (r < 50) begin
				op  = OP_UE;
				val = pick_golomb_value(1'b0);
			end else if (r < 70) begin
				op  = OP_SE;
				val = pick_golomb_value(1'b1);
			end else if (r < 80) begin
				op = OP_ALIGN;
			end else if (r < 87) begin
				op = OP_TRAIL;
			end else if (r < 95) begin
				op = OP_FLUSH;
			end else begin
				op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
			end
			send_cmd(op, val, len);
			if (op != OP_SPARE6 && op != OP_SPARE7)
				sent++;
		end
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_flush();
		test_fixed_puts();
		test_golomb_codes();
		test_align_and_trailing();
		test_spare_opcodes();
		wait_drained();
		test_backpressure();
		wait_drained();
		no_idle = 1'b1;
		test_random_stream(300);
		no_idle = 1'b0;
		test_random_stream(1450);

		wait_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
